### rtl/rpifb_pkg.sv
`timescale 1ns / 1ps
package rpifb_pkg;
  localparam int unsigned BufferDepthDefault = 32768;
  localparam int unsigned TapsDefault = 8;
  localparam int unsigned NumFilters = 3;
  localparam int unsigned CoefWidth = 24;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned YWidth = 32;
  localparam int unsigned AccWidth = 64;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegPlayback = 3'd1;
  localparam logic [2:0] RegLowpass = 3'd2;
  localparam logic [2:0] RegBandpass = 3'd3;
  localparam logic [2:0] RegHighpass = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StClear,
    StRead,
    StMac,
    StTail,
    StRound,
    StSum,
    StOut
  } state_e;
endpackage

### rtl/record_playback_iir_filter_bank_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake               | Payload
// in       | in_valid_i / in_ready_o | opcode_i .. coef_value_i
// out      | out_valid_o / out_ready_i | out_sample_o
// cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// After reset a clearing pass writes zero to each record store entry, one per
// cycle; no input or configuration beat is taken meanwhile.
// A coefficient write gives no result.
// A record or silent beat goes straight to the output state, which offers its result.
// A playback beat runs through the single shared multiply-accumulate unit, which
// walks every tap of the three filters.
// A finished result waits in the output register; the next input or configuration
// beat is taken once the output register is free.
module record_playback_iir_filter_bank_unit #(
  parameter int unsigned BUFFER_DEPTH = rpifb_pkg::BufferDepthDefault,
  parameter int unsigned TAPS = rpifb_pkg::TapsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic opcode_i,
  input  logic left_slot_i,
  input  logic signed [15:0] sample_i,
  input  logic [1:0] coef_filter_i,
  input  logic coef_feedback_i,
  input  logic [3:0] coef_index_i,
  input  logic signed [23:0] coef_value_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [15:0] out_sample_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned PW = $clog2(BUFFER_DEPTH);
  localparam int unsigned TW = $clog2(TAPS);
  localparam int unsigned HD = 3 * TAPS;
  localparam int unsigned HW = $clog2(HD);
  localparam int unsigned CD = 6 * TAPS;
  localparam int unsigned CW = $clog2(CD);
  localparam int unsigned KW = $clog2(2 * TAPS);

  logic enable_q, playback_q, lp_q, bp_q, hp_q;
  logic [PW-1:0] rec_ptr_q, play_ptr_q, clr_q;
  logic [TW-1:0] hpos_q [3];
  rpifb_pkg::state_e state_q, state_d;
  logic [1:0] filt_q;
  logic [KW-1:0] k_q;
  logic signed [15:0] dry_q;
  logic signed [63:0] acc_q;
  logic signed [33:0] sum_q;
  logic signed [15:0] res_q;
  logic out_valid_q;

  logic signed [15:0] store [BUFFER_DEPTH];
  logic signed [15:0] xh [HD];
  logic signed [31:0] yh [HD];
  logic signed [23:0] coef [CD];
  logic signed [15:0] store_rd_q;
  logic signed [23:0] coef_rd_q;
  logic signed [31:0] hist_rd_q;
  logic signed [31:0] y_q [3];

  logic in_acc, cfg_acc;
  assign in_ready_o = (state_q == rpifb_pkg::StIdle) && !out_valid_q;
  assign in_acc = in_valid_i && in_ready_o;
  assign cfg_ready_o = in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_sample_o = res_q;

  logic play_beat;
  assign play_beat = !opcode_i && left_slot_i && enable_q && playback_q;

  logic [TW-1:0] p_cur, tap_q_idx;
  logic [TW:0] tsum;
  logic [KW-1:0] kk;
  logic fb_half;
  assign p_cur = hpos_q[filt_q];
  assign fb_half = (k_q >= KW'(TAPS));
  assign kk = fb_half ? k_q - KW'(TAPS) : k_q;
  assign tsum = {1'b0, p_cur} + (TW+1)'(TAPS) - (TW+1)'(kk);
  assign tap_q_idx = (tsum >= (TW+1)'(TAPS)) ? TW'(tsum - (TW+1)'(TAPS)) : TW'(tsum);

  logic [HW-1:0] hidx;
  logic [CW-1:0] cidx;
  assign hidx = HW'(filt_q * TAPS + tap_q_idx);
  assign cidx = CW'(filt_q * 2 * TAPS + k_q);
  logic rd_fb_q, rd_zero_q, rd_live_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpifb_pkg::StClear: if (clr_q == PW'(BUFFER_DEPTH - 1)) state_d = rpifb_pkg::StIdle;
      rpifb_pkg::StIdle: begin
        if (in_acc && !opcode_i) state_d = play_beat ? rpifb_pkg::StRead : rpifb_pkg::StOut;
      end
      rpifb_pkg::StRead: state_d = rpifb_pkg::StMac;
      rpifb_pkg::StMac: if (k_q == KW'(2 * TAPS - 1) && rd_live_q) state_d = rpifb_pkg::StTail;
      rpifb_pkg::StTail: state_d = rpifb_pkg::StRound;
      rpifb_pkg::StRound: state_d = (filt_q == 2'd2) ? rpifb_pkg::StSum : rpifb_pkg::StMac;
      rpifb_pkg::StSum: state_d = rpifb_pkg::StOut;
      rpifb_pkg::StOut: state_d = rpifb_pkg::StIdle;
      default: state_d = rpifb_pkg::StIdle;
    endcase
  end

  // Memory and coefficient table ports.
  always_ff @(posedge clk_i) begin
    if (state_q == rpifb_pkg::StClear) store[clr_q] <= '0;
    else if (in_acc && !opcode_i && left_slot_i && enable_q && !playback_q)
      store[rec_ptr_q] <= sample_i;
    store_rd_q <= store[play_ptr_q];
    if (in_acc && opcode_i && coef_filter_i != 2'd3 && {1'b0, coef_index_i} < 5'(TAPS))
      coef[CW'(coef_filter_i * 2 * TAPS + coef_feedback_i * TAPS + coef_index_i)]
        <= coef_value_i;
    coef_rd_q <= coef[cidx];
  end

  logic signed [63:0] prod, y_full, y_sh;
  logic signed [31:0] y_sat;
  logic signed [31:0] xop;
  assign xop = rd_fb_q ? hist_rd_q : {{8{hist_rd_q[15]}}, hist_rd_q[15:0], 8'd0};
  assign prod = 64'(coef_rd_q) * 64'(xop);
  assign y_full = acc_q + 64'sd524288;
  assign y_sh = y_full >>> 20;
  assign y_sat = (y_sh > 64'sd2147483647) ? 32'sh7fffffff :
                 (y_sh < -64'sd2147483648) ? 32'sh80000000 : 32'(y_sh);

  logic signed [33:0] sum_c, sum_r;
  logic signed [25:0] sum_s;
  always_comb begin
    sum_c = '0;
    if (lp_q) sum_c = sum_c + 34'(y_q[0]);
    if (bp_q) sum_c = sum_c + 34'(y_q[1]);
    if (hp_q) sum_c = sum_c + 34'(y_q[2]);
    if (!lp_q && !bp_q && !hp_q) sum_c = {{10{dry_q[15]}}, dry_q, 8'd0};
    sum_r = sum_q + 34'sd128;
    sum_s = 26'(sum_r >>> 8);
  end

  // History arrays.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HD; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      if (state_q == rpifb_pkg::StMac && k_q == '0 && !rd_live_q)
        xh[HW'(filt_q * TAPS + p_cur)] <= dry_q;
      if (state_q == rpifb_pkg::StRound) yh[HW'(filt_q * TAPS + p_cur)] <= y_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_rd_q <= (k_q == '0) ? {{16{dry_q[15]}}, dry_q} :
                 fb_half ? yh[hidx] : {{16{xh[hidx][15]}}, xh[hidx]};
    rd_fb_q <= fb_half;
    rd_zero_q <= fb_half && kk == '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpifb_pkg::StClear;
      clr_q <= '0;
      enable_q <= 1'b0; playback_q <= 1'b0;
      lp_q <= 1'b0; bp_q <= 1'b0; hp_q <= 1'b0;
      rec_ptr_q <= '0; play_ptr_q <= '0;
      for (int i = 0; i < 3; i++) hpos_q[i] <= '0;
      filt_q <= '0; k_q <= '0; rd_live_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          rpifb_pkg::RegEnable: enable_q <= cfg_data_i[0];
          rpifb_pkg::RegPlayback: playback_q <= cfg_data_i[0];
          rpifb_pkg::RegLowpass: lp_q <= cfg_data_i[0];
          rpifb_pkg::RegBandpass: bp_q <= cfg_data_i[0];
          rpifb_pkg::RegHighpass: hp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        rpifb_pkg::StClear: clr_q <= clr_q + 1'b1;
        rpifb_pkg::StIdle: if (in_acc) begin
          filt_q <= '0;
          if (!opcode_i && left_slot_i && enable_q && !playback_q)
            rec_ptr_q <= (rec_ptr_q == PW'(BUFFER_DEPTH - 1)) ? '0 : rec_ptr_q + 1'b1;
        end
        rpifb_pkg::StRead: begin
          play_ptr_q <= (play_ptr_q == PW'(BUFFER_DEPTH - 1)) ? '0 : play_ptr_q + 1'b1;
          hpos_q[0] <= (hpos_q[0] == TW'(TAPS - 1)) ? '0 : hpos_q[0] + 1'b1;
          hpos_q[1] <= (hpos_q[1] == TW'(TAPS - 1)) ? '0 : hpos_q[1] + 1'b1;
          hpos_q[2] <= (hpos_q[2] == TW'(TAPS - 1)) ? '0 : hpos_q[2] + 1'b1;
          k_q <= '0; rd_live_q <= 1'b0;
        end
        rpifb_pkg::StMac: begin
          rd_live_q <= 1'b1;
          if (k_q != KW'(2 * TAPS - 1) || !rd_live_q) begin
            if (rd_live_q || k_q != '0) k_q <= k_q + 1'b1;
          end
        end
        rpifb_pkg::StRound: begin
          filt_q <= filt_q + 1'b1;
          k_q <= '0; rd_live_q <= 1'b0;
        end
        rpifb_pkg::StOut: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  logic live_d1_q;
  always_ff @(posedge clk_i) begin
    live_d1_q <= (state_q == rpifb_pkg::StMac) && (rd_live_q || k_q != '0);
    if (state_q == rpifb_pkg::StRead) dry_q <= store_rd_q;
    if (state_q == rpifb_pkg::StIdle && in_acc)
      res_q <= (!opcode_i && left_slot_i && enable_q && !playback_q) ? sample_i : '0;
    if (state_q == rpifb_pkg::StMac && !rd_live_q && k_q == '0) acc_q <= '0;
    else if (state_q == rpifb_pkg::StMac || state_q == rpifb_pkg::StTail) begin
      if (live_d1_q && !rd_zero_q) acc_q <= rd_fb_q ? acc_q - prod : acc_q + prod;
    end
    if (state_q == rpifb_pkg::StRound) y_q[filt_q] <= y_sat;
    if (state_q == rpifb_pkg::StSum) sum_q <= sum_c;
    if (state_q == rpifb_pkg::StOut && playback_q && enable_q && filt_q == 2'd3)
      res_q <= (sum_s > 26'sd32767) ? 16'sh7fff :
               (sum_s < -26'sd32768) ? 16'sh8000 : 16'(sum_s);
  end

  always_ff @(posedge clk_i) begin
    if (rst_ni) begin
      assert (!(in_ready_o && out_valid_q)) else $error("ready with pending result");
      assert (!(out_valid_q && state_q != rpifb_pkg::StIdle))
        else $error("result pending while busy");
    end
  end

  property p_out_follows;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == rpifb_pkg::StOut) |=> out_valid_q;
  endproperty
  assert property (p_out_follows) else $error("no result after out state");

  property p_clear_blocks;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == rpifb_pkg::StClear) |-> !in_ready_o;
  endproperty
  assert property (p_clear_blocks) else $error("input taken during clear");

  property p_round_filt;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == rpifb_pkg::StRound) |-> (filt_q != 2'd3);
  endproperty
  assert property (p_round_filt) else $error("bad filter index");
endmodule
